// ===== hdl/afcd_pkg.sv =====
// Shared types, frame constants and the CRC-16 byte update for the ADC frame deframer.
package afcd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 24;
  localparam int unsigned CRC_W    = 16;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned S_DATA_W = 8;
  localparam int unsigned M_DATA_W = 72;
  localparam int unsigned M_USER_W = 1;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  // Byte positions within a twelve-byte frame
  localparam logic [POS_W-1:0] POS_CHAN0 = 4'd3;
  localparam logic [POS_W-1:0] POS_CHAN1 = 4'd6;
  localparam logic [POS_W-1:0] POS_CRCW  = 4'd9;
  localparam logic [POS_W-1:0] POS_LAST  = 4'd11;

  typedef struct packed {
    logic               crc_ok;
    logic signed [23:0] channel1;
    logic signed [23:0] channel0;
    logic        [23:0] status_word;
  } afcd_result_t;

  // CRC-16, MSB first, one byte per call
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/afcd_frame_core.sv =====
// Input byte register, frame position counter, CRC and word assembly.
module afcd_frame_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [afcd_pkg::BYTE_W-1:0]   in_byte,
  output logic                          in_ready,
  output logic                          res_valid,
  output afcd_pkg::afcd_result_t        res,
  input  logic                          res_ready
);
  import afcd_pkg::*;

  logic              held;
  logic [BYTE_W-1:0] held_byte;
  logic [POS_W-1:0]  byte_position;
  logic [CRC_W-1:0]  crc_running;
  logic [WORD_W-1:0] status_hold;
  logic [WORD_W-1:0] chan0_hold;
  logic [WORD_W-1:0] chan1_hold;
  logic [CRC_W-1:0]  crc_word_hold;
  logic [CRC_W-1:0]  crc_running_next;
  logic [CRC_W-1:0]  received;
  logic              last;
  logic              advance;

  // positions 12..15 never occur; treat them as the last byte
  assign last     = (byte_position >= POS_LAST);
  assign advance  = held && (!last || res_ready);
  assign in_ready = !held || advance;

  assign crc_running_next = crc16_byte(crc_running, held_byte);
  assign received         = {crc_word_hold[BYTE_W-1:0], held_byte};

  assign res_valid           = held && last && res_ready;
  assign res.status_word     = status_hold;
  assign res.channel0        = chan0_hold;
  assign res.channel1        = chan1_hold;
  assign res.crc_ok          = (crc_running == received);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
    if (in_valid && in_ready) begin
      held_byte <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      crc_running   <= CRC_INIT;
      status_hold   <= '0;
      chan0_hold    <= '0;
      chan1_hold    <= '0;
      crc_word_hold <= '0;
    end else if (advance) begin
      if (byte_position < POS_CHAN0) begin
        status_hold <= {status_hold[WORD_W-BYTE_W-1:0], held_byte};
      end else if (byte_position < POS_CHAN1) begin
        chan0_hold <= {chan0_hold[WORD_W-BYTE_W-1:0], held_byte};
      end else if (byte_position < POS_CRCW) begin
        chan1_hold <= {chan1_hold[WORD_W-BYTE_W-1:0], held_byte};
      end
      if (last) begin
        byte_position <= '0;
        crc_running   <= CRC_INIT;
        crc_word_hold <= '0;
      end else begin
        byte_position <= byte_position + POS_W'(1);
        if (byte_position < POS_CRCW) begin
          crc_running <= crc_running_next;
        end else begin
          crc_word_hold <= {crc_word_hold[BYTE_W-1:0], held_byte};
        end
      end
    end
  end

endmodule

// ===== hdl/afcd_out_reg.sv =====
// Result register on the master side; frees as the downstream takes it.
module afcd_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   res_valid,
  input  afcd_pkg::afcd_result_t res,
  output logic                   res_ready,
  output logic                   out_valid,
  output afcd_pkg::afcd_result_t out_res,
  input  logic                   out_ready
);
  import afcd_pkg::*;

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res_valid) begin
      out_res <= res;
    end
  end

endmodule

// ===== hdl/adc_frame_crc_deframer_unit.sv =====
// Top level of the ADC frame deframer with CRC-16 check.
// Takes one byte per transfer from a two-channel converter link and groups them
// into twelve-byte frames: status, channel 0, channel 1 and CRC, each a
// big-endian 24-bit word. CRC-16 (poly 0x1021, init 0xFFFF, MSB first, no
// reflection, no final xor) runs over the first nine bytes and is compared
// with the low 16 bits of the CRC word; the top CRC byte is not checked.
// One result word leaves after the twelfth byte, then the frame counter
// wraps. There is no framing mark: a lost byte shifts every later frame
// until reset. Rate: one byte per clock, sustained; a result held by a
// stalled master side only stops the input at the next frame end. Each
// byte passes the input register, and the frame result is captured in
// the result register. The CRC byte update (eight unrolled shift/xor
// steps) feeds the running CRC register; the result sees only a compare.
module adc_frame_crc_deframer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [afcd_pkg::S_DATA_W-1:0]   s_tdata,   // [7:0] rx_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [afcd_pkg::M_DATA_W-1:0]   m_tdata,   // [23:0] status_word,
                                                     // [47:24] channel0,
                                                     // [71:48] channel1
  output logic [afcd_pkg::M_USER_W-1:0]   m_tuser    // [0] crc_ok
);
  import afcd_pkg::*;

  // core to result register
  logic         res_valid;
  logic         res_ready;
  afcd_result_t res;
  afcd_result_t out_res;

  afcd_frame_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_byte   (s_tdata[BYTE_W-1:0]),
    .in_ready  (s_tready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  afcd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (m_tvalid),
    .out_res   (out_res),
    .out_ready (m_tready)
  );

  // channels are emitted as their raw 24-bit two's complement patterns
  assign m_tdata = {out_res.channel1, out_res.channel0, out_res.status_word};
  assign m_tuser = out_res.crc_ok;

endmodule
